FILE: rtl/first_occurrence_binary_search_macros.svh
// assertion macros for the rtl
`ifndef FIRST_OCCURRENCE_BINARY_SEARCH_MACROS_SVH
`define FIRST_OCCURRENCE_BINARY_SEARCH_MACROS_SVH

// same-cycle implication, held off during reset
`define FOBS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fobs assertion failed");

// next-cycle implication, held off during reset
`define FOBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fobs assertion failed");

`endif

FILE: rtl/fobs_pkg.sv
`default_nettype none

package fobs_pkg;

    // default sizing
    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int KEY_WIDTH_DEF   = 32;

    // fixed field widths
    localparam int LEN_W = 13;
    localparam int IDX_W = 12;
    localparam int KEY_W = 32;

    // operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // input item
    typedef struct packed {
        logic             op;
        logic [IDX_W-1:0] entry_index;
        logic [KEY_W-1:0] key_value;
    } t_in_item;

    // result item
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] first_index;
    } t_out_item;

endpackage

`default_nettype wire

FILE: rtl/fobs_key_ram.sv
`default_nettype none

module fobs_key_ram #(
    parameter int TABLE_DEPTH = fobs_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_WIDTH   = fobs_pkg::KEY_WIDTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_we,
    input  wire logic                           i_re,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0] i_addr,
    input  wire logic [KEY_WIDTH-1:0]           i_wdata,
    output logic      [KEY_WIDTH-1:0]           o_rdata
);
    import fobs_pkg::*;

    logic [KEY_WIDTH-1:0] r_mem [TABLE_DEPTH];
    logic [KEY_WIDTH-1:0] r_rdata;

    // single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/first_occurrence_binary_search.sv
// channel   dir  signals                               moves
// input     in   i_in_valid / o_in_ready / i_in_data   load (no result) or query
// output    out  o_out_valid / i_out_ready / o_out_data one result per query
// config    in   i_cfg_we / i_cfg_wdata                table length, no wait
//
// a load is written to the table as it is accepted; a query takes P probes, P at most
// ceil(log2(length + 1)), at one key table read per cycle, each read registered
// a zero-length query skips the probes; a finished result waits in the output
// register and only stalls the next query at its final step
// reset is synchronous active low; the key table itself is not cleared
`default_nettype none
`include "first_occurrence_binary_search_macros.svh"

module first_occurrence_binary_search #(
    parameter int TABLE_DEPTH = fobs_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_WIDTH   = fobs_pkg::KEY_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire fobs_pkg::t_in_item           i_in_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output fobs_pkg::t_out_item               o_out_data,
    input  wire logic                         i_cfg_we,
    input  wire logic [fobs_pkg::LEN_W-1:0]   i_cfg_wdata
);
    import fobs_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int PW = AW + 1;
    localparam int LW = (PW > LEN_W) ? PW : LEN_W;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_PROBE = 3'b010,
        S_FIN   = 3'b100
    } t_state;

    t_state               r_state, n_state;
    logic [LEN_W-1:0]     r_table_length;
    logic [PW-1:0]        r_low, n_low;
    logic [PW-1:0]        r_hi, n_hi;
    logic [AW-1:0]        r_mid;
    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic [AW-1:0]        r_best, n_best;
    logic                 r_best_v, n_best_v;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out_data, n_out_data;

    logic                 w_accept;
    logic                 w_out_free;
    logic [PW-1:0]        w_len_clamp;
    logic [PW:0]          w_sum;
    logic [AW-1:0]        w_rd_addr;
    logic                 w_rd_en;
    logic                 w_wr_en;
    logic [KEY_WIDTH-1:0] w_rdata;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // length clamped to the table depth
    assign w_len_clamp = (LW'(r_table_length) > LW'(TABLE_DEPTH)) ?
                         PW'(TABLE_DEPTH) : PW'(r_table_length);

    // midpoint of the next window, high is kept exclusive
    assign w_sum     = {1'b0, n_low} + {1'b0, n_hi} - {{PW{1'b0}}, 1'b1};
    assign w_rd_addr = w_sum[AW:1];

    // loads go straight to the table when the index is in range
    assign w_wr_en = w_accept && (i_in_data.op == OP_LOAD) &&
                     (LW'(i_in_data.entry_index) < LW'(TABLE_DEPTH));

    fobs_key_ram #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr_en),
        .i_re    (w_rd_en),
        .i_addr  (w_wr_en ? AW'(i_in_data.entry_index) : w_rd_addr),
        .i_wdata (KEY_WIDTH'(i_in_data.key_value)),
        .o_rdata (w_rdata)
    );

    // search sequencer
    always_comb begin
        n_state     = r_state;
        n_low       = r_low;
        n_hi        = r_hi;
        n_key       = r_key;
        n_best      = r_best;
        n_best_v    = r_best_v;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        w_rd_en     = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_in_data.op == OP_QUERY)) begin
                    n_low    = '0;
                    n_hi     = w_len_clamp;
                    n_key    = KEY_WIDTH'(i_in_data.key_value);
                    n_best_v = 1'b0;
                    if (w_len_clamp != '0) begin
                        w_rd_en = 1'b1;
                        n_state = S_PROBE;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_PROBE: begin
                // narrow the window on the entry read last cycle
                if (w_rdata == r_key) begin
                    n_best   = r_mid;
                    n_best_v = 1'b1;
                    n_hi     = {1'b0, r_mid};
                end else if (w_rdata > r_key) begin
                    n_hi = {1'b0, r_mid};
                end else begin
                    n_low = {1'b0, r_mid} + PW'(1);
                end
                if (n_low < n_hi) begin
                    w_rd_en = 1'b1;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hand the result over once the output register is free
                if (w_out_free) begin
                    n_out_valid            = 1'b1;
                    n_out_data.found       = r_best_v;
                    n_out_data.first_index = r_best_v ? IDX_W'(r_best) : '0;
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_table_length <= '0;
            r_best_v       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_best_v    <= n_best_v;
            if (i_cfg_we) begin
                r_table_length <= i_cfg_wdata;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_low      <= n_low;
        r_hi       <= n_hi;
        r_key      <= n_key;
        r_best     <= n_best;
        r_out_data <= n_out_data;
        if (w_rd_en) begin
            r_mid <= w_rd_addr;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // search window is never empty while probing
    `FOBS_ASSERT_IMPL(a_window_open, i_clk, i_rst_n, r_state == S_PROBE, r_low < r_hi)
    // once a match is held the window stays at or below it
    `FOBS_ASSERT_IMPL(a_best_above, i_clk, i_rst_n, (r_state == S_PROBE) && r_best_v, r_hi <= {1'b0, r_best})
    // a finished search with a free output register delivers next cycle
    `FOBS_ASSERT_NEXT(a_fin_out, i_clk, i_rst_n, (r_state == S_FIN) && w_out_free, r_out_valid && (r_state == S_IDLE))
    // a miss carries a zero index
    `FOBS_ASSERT_IMPL(a_miss_zero, i_clk, i_rst_n, r_out_valid && !r_out_data.found, r_out_data.first_index == '0)

endmodule

`default_nettype wire

FILE: tb/sv/first_occurrence_binary_search_tb.sv
`default_nettype none

module first_occurrence_binary_search_tb;

    import fobs_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int SETTLE_WAIT = 20;
    localparam int HOLD_CYCLES = 400;
    localparam int RAND_ITEMS  = 2000;

    // dut ports
    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    t_in_item           i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    t_out_item          o_out_data;
    logic               i_cfg_we;
    logic [LEN_W-1:0]   i_cfg_wdata;

    // items waiting to be offered and results still owed by the block
    t_in_item           pending_items[$];
    t_out_item          expected_results[$];

    // key table as the block should hold it, and the length in force
    logic [KEY_W-1:0]   key_model [TABLE_DEPTH_DEF];
    logic [LEN_W-1:0]   model_len;

    // what the stimulus side has sent so far, used to pick hitting keys
    logic [KEY_W-1:0]   stim_table [TABLE_DEPTH_DEF];
    bit                 stim_written [TABLE_DEPTH_DEF];

    logic               in_fire;
    logic               send_steady;
    logic               recv_steady;
    logic               hold_req;
    int                 send_gap;
    int                 stall_left;
    int                 hold_left;
    int                 idle_cycles;
    int                 fail_count;
    int                 rand_items;
    t_out_item          want;

    first_occurrence_binary_search dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // first-occurrence search over the used part of the table
    function automatic t_out_item search_first_key(logic [KEY_W-1:0] key);
        int        lo;
        int        hi;
        int        mid;
        int        best;
        int        span;
        t_out_item res;
        span = (model_len > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(model_len);
        lo   = 0;
        hi   = span - 1;
        best = -1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (key_model[mid] == key) begin
                best = mid;
                hi   = mid - 1;
            end else if (key_model[mid] > key) begin
                hi = mid - 1;
            end else begin
                lo = mid + 1;
            end
        end
        res.found       = (best >= 0);
        res.first_index = (best >= 0) ? IDX_W'(best) : '0;
        return res;
    endfunction

    // input driver: offers queued items, holds each until its transfer
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_fire) begin
            // item still on offer
        end else if (send_gap > 0) begin
            send_gap--;
            i_in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
            i_in_data  <= pending_items.pop_front();
            i_in_valid <= 1'b1;
            send_gap = send_steady ? 0 : pick_gap();
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // output side: random stalls plus the long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            stall_left = recv_steady ? 0 : pick_gap();
        end
    end

    // monitor: predicts on input transfers, checks output transfers
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_fire <= 1'b0;
            idle_cycles = 0;
        end else begin
            in_fire <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) begin
                if (i_in_data.op == OP_LOAD)
                    key_model[i_in_data.entry_index] = i_in_data.key_value;
                else
                    expected_results.push_back(search_first_key(i_in_data.key_value));
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected, found %0b index %0d",
                             $time, o_out_data.found, o_out_data.first_index);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_data.found !== want.found) begin
                        $display("%0t: found expected %0b actual %0b",
                                 $time, want.found, o_out_data.found);
                        fail_count++;
                    end
                    if (o_out_data.first_index !== want.first_index) begin
                        $display("%0t: first_index expected %0d actual %0d",
                                 $time, want.first_index, o_out_data.first_index);
                        fail_count++;
                    end
                end
            end
            // watchdog on cycles without any transfer
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("simulation failed");
                    $finish;
                end
            end
        end
    end

    task automatic push_load(int idx, logic [KEY_W-1:0] key);
        t_in_item it;
        it.op          = OP_LOAD;
        it.entry_index = IDX_W'(idx);
        it.key_value   = key;
        stim_table[idx]   = key;
        stim_written[idx] = 1'b1;
        pending_items.push_back(it);
        rand_items++;
    endtask

    // write any entry the search for this key would meet unwritten
    task automatic prepare_path(logic [KEY_W-1:0] key);
        int lo;
        int hi;
        int mid;
        int span;
        span = (model_len > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(model_len);
        lo   = 0;
        hi   = span - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (!stim_written[mid]) begin
                if ($urandom_range(0, 3) == 0) push_load(mid, key);
                else                           push_load(mid, KEY_W'(mid) << 20);
            end
            if (stim_table[mid] >= key) hi = mid - 1;
            else                        lo = mid + 1;
        end
    endtask

    task automatic push_query(logic [KEY_W-1:0] key);
        t_in_item it;
        prepare_path(key);
        it.op          = OP_QUERY;
        it.entry_index = IDX_W'($urandom_range(0, TABLE_DEPTH_DEF - 1));
        it.key_value   = key;
        pending_items.push_back(it);
        rand_items++;
    endtask

    // everything sent, every result back, then let a late load finish
    task automatic wait_idle();
        while (pending_items.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_WAIT) @(negedge i_clk);
    endtask

    task automatic write_length(int len);
        model_len = LEN_W'(len);
        i_cfg_wdata <= LEN_W'(len);
        i_cfg_we    <= 1'b1;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // one random phase: new length, optional reload of the prefix, then queries
    task automatic run_phase(int ph);
        int             r;
        int             len;
        int             span;
        int             nq;
        int             i;
        int             k;
        bit             seen;
        longint         acc;
        logic [KEY_W-1:0] key;
        wait_idle();
        send_steady = ($urandom_range(0, 3) == 0);
        recv_steady = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        if (r < 65)      len = $urandom_range(1, 32);
        else if (r < 85) len = $urandom_range(33, 300);
        else if (r < 90) len = 0;
        else if (r < 94) len = TABLE_DEPTH_DEF;
        else if (r < 97) len = $urandom_range(TABLE_DEPTH_DEF + 1, 8191);
        else             len = $urandom_range(2, TABLE_DEPTH_DEF - 1);
        write_length(len);
        span = (len > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : len;

        // long output hold-off while the sender keeps offering
        if (ph == 1 || ph % 17 == 5) begin
            send_steady = 1'b1;
            hold_req    = 1'b1;
        end

        // reload short tables, mostly sorted with duplicates
        if (span > 0 && span <= 300) begin
            if ($urandom_range(0, 99) < 80) begin
                r = $urandom_range(0, 99);
                if (r < 30)      acc = 0;
                else if (r < 45) acc = 64'hFFFF_FFFF - span;
                else             acc = $urandom;
                for (i = 0; i < span; i++) begin
                    push_load(i, (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[KEY_W-1:0]);
                    if ($urandom_range(0, 9) == 0) acc += $urandom_range(4, 1000);
                    else                           acc += $urandom_range(0, 2);
                end
            end else begin
                for (i = 0; i < span; i++)
                    push_load(i, $urandom_range(0, 15));
            end
        end

        nq = (ph == 1) ? 40 : $urandom_range(8, 40);
        for (i = 0; i < nq; i++) begin
            // stray loads anywhere in the table
            if ($urandom_range(0, 99) < 8)
                push_load($urandom_range(0, TABLE_DEPTH_DEF - 1), $urandom);
            r = $urandom_range(0, 99);
            k = (span > 0) ? $urandom_range(0, span - 1) : 0;
            seen = (span > 0) && stim_written[k];
            if (seen && r < 55)      key = stim_table[k];
            else if (seen && r < 70) key = stim_table[k] + ($urandom_range(0, 1) ? 1 : -1);
            else if (r < 80)         key = $urandom_range(0, 1) ? 32'hFFFF_FFFF : '0;
            else                     key = $urandom;
            push_query(key);
        end
    endtask

    // stimulus
    initial begin
        int i;
        int ph;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        in_fire     = 1'b0;
        send_steady = 1'b0;
        recv_steady = 1'b0;
        hold_req    = 1'b0;
        send_gap    = 0;
        stall_left  = 0;
        hold_left   = 0;
        fail_count  = 0;
        rand_items  = 0;
        model_len   = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero length: nothing is probed, nothing is found
        write_length(0);
        push_query(32'h0000_0000);
        push_query(32'hFFFF_FFFF);

        // full length: ends pinned, entries on each probe path written as needed
        wait_idle();
        write_length(TABLE_DEPTH_DEF);
        push_load(0, 32'd0);
        push_load(TABLE_DEPTH_DEF - 1, 32'hFFFF_FFFF);
        push_query(32'd0);
        push_query(32'hFFFF_FFFF);
        push_query(32'd7);
        push_query(32'h8000_0000);

        // length beyond the table saturates
        wait_idle();
        write_length(8191);
        push_query(32'd0);
        push_query(32'hFFFF_FFFF);
        wait_idle();
        write_length(TABLE_DEPTH_DEF + 1);
        push_query(32'hFFFF_FFFF);

        // single entry
        wait_idle();
        write_length(1);
        push_query(32'd0);
        push_query(32'd5);

        // random phases
        rand_items = 0;
        ph = 0;
        while (rand_items < RAND_ITEMS) begin
            run_phase(ph);
            ph++;
        end

        wait_idle();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
